### rtl/core/ccl_pkg.sv
// shared types and constants of the charge connector lock controller
package ccl_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned BMS_W  = 8;
  localparam int unsigned VIFC_W = 16;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned IN_W   = 32;
  localparam int unsigned OUT_W  = 8;

  localparam logic [TICK_W-1:0] RESET_TICKS = 16'd1000;
  localparam logic [TICK_W-1:0] TICKS_MAX   = 16'hFFFF;

  localparam logic [BMS_W-1:0] BMS_ST_1     = 8'h01;
  localparam logic [BMS_W-1:0] BMS_ST_2     = 8'h02;
  localparam logic [BMS_W-1:0] BMS_ST_3     = 8'h03;
  localparam logic [BMS_W-1:0] BMS_ST_RESET = BMS_ST_1;

  localparam logic [VIFC_W-1:0] VIFC_ST_MASK = 16'h3000;

  localparam logic [CODE_W-1:0] CODE_IDLE      = 3'd0;
  localparam logic [CODE_W-1:0] CODE_LOCKING   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_UNLOCKING = 3'd2;
  localparam logic [CODE_W-1:0] CODE_LOCKED    = 3'd3;
  localparam logic [CODE_W-1:0] CODE_UNLOCKED  = 3'd4;

  typedef enum logic [1:0] {
    REG_LOCK_RUN   = 2'd0,
    REG_UNLOCK_RUN = 2'd1,
    REG_FB_DELAY   = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_LOCKING   = 5'b00010,
    PH_UNLOCKING = 5'b00100,
    PH_LOCKED    = 5'b01000,
    PH_UNLOCKED  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] lock_run_ticks;
    logic [TICK_W-1:0] unlock_run_ticks;
    logic [TICK_W-1:0] feedback_delay_ticks;
  } ccl_cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [TICK_W-1:0] elapsed_ticks;
    logic              button_prev;
    logic              unlock_latched;
    logic [BMS_W-1:0]  prev_bms_status;
  } ccl_state_t;

  typedef struct packed {
    logic              lock_request;
    logic              charging;
    logic              button_pin;
    logic              feedback_pin;
    logic [BMS_W-1:0]  bms_status;
    logic              bms_valid;
    logic [VIFC_W-1:0] vifc_status;
    logic              vifc_valid;
    logic              self_test_running;
    logic              self_test_pending;
  } ccl_item_t;

  typedef struct packed {
    logic              motor_lock_drive;
    logic              motor_unlock_drive;
    logic [CODE_W-1:0] phase;
    logic              locked_flag;
    logic              lock_failed;
    logic              self_test_request;
  } ccl_res_t;

endpackage

### rtl/core/ccl_step.sv
// one tick of the lock state machine, button latch and self-test detect
module ccl_step (
  input  ccl_pkg::ccl_cfg_t   cfg,
  input  ccl_pkg::ccl_state_t cur,
  input  ccl_pkg::ccl_item_t  item,
  output ccl_pkg::ccl_state_t nxt,
  output ccl_pkg::ccl_res_t   res
);
  import ccl_pkg::*;

  logic              pressed;
  logic              engaged;
  logic              start_ok;
  logic              latched;
  logic [BMS_W-1:0]  bms;
  logic [VIFC_W-1:0] vifc;
  logic              rise;
  logic              ask;
  logic [TICK_W-1:0] elapsed_inc;
  logic              failed;

  always_comb begin
    pressed  = ~item.button_pin;
    engaged  = ~item.feedback_pin;
    start_ok = ~item.charging;
    bms      = item.bms_valid ? item.bms_status : '0;
    vifc     = item.vifc_valid ? item.vifc_status : '0;
    latched  = cur.unlock_latched | (pressed & ~cur.button_prev);

    rise = (cur.prev_bms_status == BMS_ST_1 && bms == BMS_ST_2) ||
           (cur.prev_bms_status == BMS_ST_1 && bms == BMS_ST_3) ||
           (cur.prev_bms_status == BMS_ST_2 && bms == BMS_ST_3);
    ask  = |(vifc & VIFC_ST_MASK);

    // saturating count, the start tick leaves it at zero
    elapsed_inc = (cur.elapsed_ticks == TICKS_MAX) ? cur.elapsed_ticks
                                                   : cur.elapsed_ticks + 1'b1;

    nxt                 = cur;
    nxt.button_prev     = pressed;
    nxt.unlock_latched  = latched;
    nxt.prev_bms_status = bms;
    failed              = 1'b0;

    unique case (cur.phase)
      PH_IDLE: begin
        if (item.lock_request && start_ok) begin
          nxt.phase         = PH_LOCKING;
          nxt.elapsed_ticks = '0;
        end else if (latched && start_ok) begin
          nxt.phase          = PH_UNLOCKING;
          nxt.unlock_latched = 1'b0;
          nxt.elapsed_ticks  = '0;
        end
      end
      PH_LOCKING: begin
        nxt.elapsed_ticks = elapsed_inc;
        if (elapsed_inc >= cfg.lock_run_ticks && elapsed_inc >= cfg.feedback_delay_ticks) begin
          if (engaged) begin
            nxt.phase = PH_LOCKED;
          end else begin
            nxt.phase = PH_IDLE;
            failed    = 1'b1;
          end
        end
      end
      PH_UNLOCKING: begin
        nxt.elapsed_ticks = elapsed_inc;
        if (elapsed_inc >= cfg.unlock_run_ticks) begin
          nxt.phase = PH_UNLOCKED;
        end
      end
      PH_LOCKED: begin
        if (latched && start_ok) begin
          nxt.phase          = PH_UNLOCKING;
          nxt.unlock_latched = 1'b0;
          nxt.elapsed_ticks  = '0;
        end
      end
      PH_UNLOCKED: begin
        if (item.lock_request && start_ok) begin
          nxt.phase         = PH_LOCKING;
          nxt.elapsed_ticks = '0;
        end
      end
      default: begin
        nxt.phase = cur.phase;
      end
    endcase

    res.motor_lock_drive   = (nxt.phase == PH_LOCKING);
    res.motor_unlock_drive = (nxt.phase == PH_UNLOCKING);
    res.locked_flag        = (nxt.phase == PH_LOCKED);
    res.lock_failed        = failed;
    res.self_test_request  = (bms != cur.prev_bms_status) && rise && ask &&
                             !item.self_test_running && !item.self_test_pending;
    unique case (nxt.phase)
      PH_IDLE:      res.phase = CODE_IDLE;
      PH_LOCKING:   res.phase = CODE_LOCKING;
      PH_UNLOCKING: res.phase = CODE_UNLOCKING;
      PH_LOCKED:    res.phase = CODE_LOCKED;
      PH_UNLOCKED:  res.phase = CODE_UNLOCKED;
      default:      res.phase = CODE_IDLE;
    endcase
  end

endmodule

### rtl/core/charge_connector_lock_controller.sv
// A transferred tick item waits in the input register; its result is then
// offered from the result register. Throughput: one tick item per cycle
// unless the output stalls; the state registers update in the same cycle the
// item moves into the result register, so ticks follow back to back.
// Reset (rst_n low, synchronous): phase idle, elapsed count zero, button not
// pressed, no latched unlock, previous battery status 0x01, all timers 1000.
module charge_connector_lock_controller (
  input  logic        clk,
  input  logic        rst_n,
  // lock_request[0] charging[1] button_pin[2] feedback_pin[3] bms_status[11:4]
  // bms_valid[12] vifc_status[28:13] vifc_valid[29] self_test_running[30]
  // self_test_pending[31]
  input  logic [31:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // motor_lock_drive[0] motor_unlock_drive[1] phase[4:2] locked_flag[5]
  // lock_failed[6] self_test_request[7]
  output logic [7:0]  out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ccl_pkg::*;

  ccl_cfg_t   cfg_r;
  ccl_state_t state_r;
  ccl_state_t state_nxt;
  ccl_item_t  item_r;
  ccl_item_t  item_in;
  ccl_res_t   res_nxt;
  logic       in_valid_r;
  logic       out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic       advance;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_LOCK_RUN:   cfg_prdata = {16'd0, cfg_r.lock_run_ticks};
      REG_UNLOCK_RUN: cfg_prdata = {16'd0, cfg_r.unlock_run_ticks};
      REG_FB_DELAY:   cfg_prdata = {16'd0, cfg_r.feedback_delay_ticks};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lock_run_ticks       <= RESET_TICKS;
      cfg_r.unlock_run_ticks     <= RESET_TICKS;
      cfg_r.feedback_delay_ticks <= RESET_TICKS;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LOCK_RUN:   cfg_r.lock_run_ticks       <= cfg_pwdata[15:0];
        REG_UNLOCK_RUN: cfg_r.unlock_run_ticks     <= cfg_pwdata[15:0];
        REG_FB_DELAY:   cfg_r.feedback_delay_ticks <= cfg_pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    item_in.lock_request      = in_tdata[0];
    item_in.charging          = in_tdata[1];
    item_in.button_pin        = in_tdata[2];
    item_in.feedback_pin      = in_tdata[3];
    item_in.bms_status        = in_tdata[11:4];
    item_in.bms_valid         = in_tdata[12];
    item_in.vifc_status       = in_tdata[28:13];
    item_in.vifc_valid        = in_tdata[29];
    item_in.self_test_running = in_tdata[30];
    item_in.self_test_pending = in_tdata[31];
  end

  // item leaves the input register when the result register is free or drains
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  ccl_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase           <= PH_IDLE;
      state_r.elapsed_ticks   <= '0;
      state_r.button_prev     <= 1'b0;
      state_r.unlock_latched  <= 1'b0;
      state_r.prev_bms_status <= BMS_ST_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {res_nxt.self_test_request, res_nxt.lock_failed, res_nxt.locked_flag,
                     res_nxt.phase, res_nxt.motor_unlock_drive, res_nxt.motor_lock_drive};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("state changed without a tick transfer");

  a_fail_from_locking: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.lock_failed |-> state_r.phase == PH_LOCKING)
    else $error("lock failure outside the locking phase");

  a_motors_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[1]))
    else $error("both motors driven");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result lost");

  a_run_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    advance && state_r.phase != PH_LOCKING && state_nxt.phase == PH_LOCKING
    |=> state_r.elapsed_ticks == '0)
    else $error("lock run started with nonzero count");

endmodule
